// ===== sv/srd_pkg.sv =====
`default_nettype none

package srd_pkg;

   // Operand and result fields are fixed at 16 bits
   localparam int FieldW       = 16;
   // Accumulator width used when the top level is not overridden
   localparam int DefaultWidth = 16;
   // Entries in the queue between classifier and divider pipe
   localparam int QueueDepth   = 2;
   localparam int QueuePtrW    = $clog2(QueueDepth);
   localparam int QueueCntW    = $clog2(QueueDepth + 1);

   // Per-item sideband that rides beside the magnitudes
   typedef struct packed {
      logic              quo_neg;
      logic              rem_neg;
      logic              div_zero;
      logic [FieldW-1:0] dividend;
   } tag_type;

endpackage

`default_nettype wire

// ===== sv/srd_front.sv =====
`default_nettype none

module srd_front #(
   parameter int WIDTH = srd_pkg::DefaultWidth
) (
   input  wire logic                       start,
   input  wire logic                       queue_full,
   input  wire logic [srd_pkg::FieldW-1:0] req_dividend,
   input  wire logic [srd_pkg::FieldW-1:0] req_divisor,
   output logic                            push,
   output logic [WIDTH-1:0]                push_num,
   output logic [WIDTH-1:0]                push_den,
   output srd_pkg::tag_type                push_tag
);
   import srd_pkg::*;

   localparam int MagW = (WIDTH > FieldW + 1) ? WIDTH : FieldW + 1;
   localparam logic [MagW-1:0] MagLim = MagW'((64'd1 << (WIDTH - 1)) - 64'd1);

   logic [FieldW:0]  dvd_ext;
   logic [FieldW:0]  dvs_ext;
   logic [FieldW:0]  dvd_abs;
   logic [FieldW:0]  dvs_abs;
   logic [MagW-1:0]  dvd_wide;
   logic [MagW-1:0]  dvs_wide;
   logic [MagW-1:0]  dvd_sat;
   logic [MagW-1:0]  dvs_sat;

   // take the beat whenever the queue has room
   assign push = start && !queue_full;

   always_comb begin
      dvd_ext  = {req_dividend[FieldW-1], req_dividend};
      dvs_ext  = {req_divisor[FieldW-1], req_divisor};
      dvd_abs  = req_dividend[FieldW-1] ? ((FieldW+1)'(0) - dvd_ext) : dvd_ext;
      dvs_abs  = req_divisor[FieldW-1]  ? ((FieldW+1)'(0) - dvs_ext) : dvs_ext;
      dvd_wide = MagW'(dvd_abs);
      dvs_wide = MagW'(dvs_abs);
      // clamp magnitudes that do not fit below the accumulator sign bit
      dvd_sat  = (dvd_wide > MagLim) ? MagLim : dvd_wide;
      dvs_sat  = (dvs_wide > MagLim) ? MagLim : dvs_wide;
      push_num = dvd_sat[WIDTH-1:0];
      push_den = dvs_sat[WIDTH-1:0];

      push_tag.quo_neg  = req_dividend[FieldW-1] ^ req_divisor[FieldW-1];
      push_tag.rem_neg  = req_dividend[FieldW-1];
      push_tag.div_zero = (req_divisor == '0);
      push_tag.dividend = req_dividend;
   end

endmodule

`default_nettype wire

// ===== sv/srd_queue.sv =====
`default_nettype none

module srd_queue #(
   parameter int WIDTH = srd_pkg::DefaultWidth
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_num,
   input  wire logic [WIDTH-1:0] push_den,
   input  srd_pkg::tag_type      push_tag,
   output logic                  full,
   output logic                  head_valid,
   output logic [WIDTH-1:0]      head_num,
   output logic [WIDTH-1:0]      head_den,
   output srd_pkg::tag_type      head_tag
);
   import srd_pkg::*;

   logic [WIDTH-1:0]     num_ff [QueueDepth];
   logic [WIDTH-1:0]     den_ff [QueueDepth];
   tag_type              tag_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0] count_ff, count_in;
   logic                 pop;

   assign full       = (count_ff == QueueCntW'(QueueDepth));
   assign head_valid = (count_ff != '0);
   // the divider pipe never stalls: drop the head every cycle it is present
   assign pop        = head_valid;
   assign head_num   = num_ff[rd_ptr_ff];
   assign head_den   = den_ff[rd_ptr_ff];
   assign head_tag   = tag_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         num_ff[wr_ptr_ff] <= push_num;
         den_ff[wr_ptr_ff] <= push_den;
         tag_ff[wr_ptr_ff] <= push_tag;
      end
   end

endmodule

`default_nettype wire

// ===== sv/srd_back.sv =====
`default_nettype none

module srd_back #(
   parameter int WIDTH = srd_pkg::DefaultWidth
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic [WIDTH-1:0]           in_num,
   input  wire logic [WIDTH-1:0]           in_den,
   input  srd_pkg::tag_type                in_tag,
   output logic                            rsp_valid,
   output logic [srd_pkg::FieldW-1:0]      rsp_quotient,
   output logic [srd_pkg::FieldW-1:0]      rsp_remainder,
   output logic                            rsp_divide_by_zero
);
   import srd_pkg::*;

   localparam int ResW = (WIDTH > FieldW) ? WIDTH : FieldW;

   // one register stage per quotient bit
   logic             vld_ff [WIDTH];
   logic [WIDTH-1:0] acc_ff [WIDTH];
   logic [WIDTH-1:0] quo_ff [WIDTH];
   logic [WIDTH-1:0] den_ff [WIDTH];
   tag_type          tag_ff [WIDTH];
   logic             vld_in [WIDTH];
   logic [WIDTH-1:0] acc_in [WIDTH];
   logic [WIDTH-1:0] quo_in [WIDTH];
   logic [WIDTH-1:0] den_in [WIDTH];
   tag_type          tag_in [WIDTH];

   logic              out_vld_ff;
   logic [FieldW-1:0] out_quo_ff, out_quo_in;
   logic [FieldW-1:0] out_rem_ff, out_rem_in;
   logic              out_dbz_ff, out_dbz_in;
   logic [ResW-1:0]   quo_ext;
   logic [ResW-1:0]   rem_ext;
   logic [ResW-1:0]   quo_sgn;
   logic [ResW-1:0]   rem_sgn;

   for (genvar k = 0; k < WIDTH; k++) begin : g_round
      logic [WIDTH-1:0] src_acc;
      logic [WIDTH-1:0] src_quo;
      logic [WIDTH-1:0] src_den;
      tag_type          src_tag;
      logic             src_vld;
      logic [WIDTH-1:0] acc_sh;
      logic [WIDTH:0]   diff;

      if (k == 0) begin : g_head
         assign src_vld = in_valid;
         assign src_acc = '0;
         assign src_quo = in_num;
         assign src_den = in_den;
         assign src_tag = in_tag;
      end else begin : g_body
         assign src_vld = vld_ff[k-1];
         assign src_acc = acc_ff[k-1];
         assign src_quo = quo_ff[k-1];
         assign src_den = den_ff[k-1];
         assign src_tag = tag_ff[k-1];
      end

      // shift in the next dividend bit, trial-subtract, restore on borrow
      always_comb begin
         acc_sh    = {src_acc[WIDTH-2:0], src_quo[WIDTH-1]};
         diff      = {1'b0, acc_sh} - {1'b0, src_den};
         vld_in[k] = src_vld;
         den_in[k] = src_den;
         tag_in[k] = src_tag;
         if (!diff[WIDTH]) begin
            acc_in[k] = diff[WIDTH-1:0];
            quo_in[k] = {src_quo[WIDTH-2:0], 1'b1};
         end else begin
            acc_in[k] = acc_sh;
            quo_in[k] = {src_quo[WIDTH-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_in[k];
         end
      end

      always_ff @(posedge clock) begin
         acc_ff[k] <= acc_in[k];
         quo_ff[k] <= quo_in[k];
         den_ff[k] <= den_in[k];
         tag_ff[k] <= tag_in[k];
      end
   end

   // apply signs, or pass the dividend through on a zero divisor
   always_comb begin
      quo_ext = ResW'(quo_ff[WIDTH-1]);
      rem_ext = ResW'(acc_ff[WIDTH-1]);
      quo_sgn = tag_ff[WIDTH-1].quo_neg ? (ResW'(0) - quo_ext) : quo_ext;
      rem_sgn = tag_ff[WIDTH-1].rem_neg ? (ResW'(0) - rem_ext) : rem_ext;
      out_dbz_in = tag_ff[WIDTH-1].div_zero;
      if (tag_ff[WIDTH-1].div_zero) begin
         out_quo_in = '0;
         out_rem_in = tag_ff[WIDTH-1].dividend;
      end else begin
         out_quo_in = quo_sgn[FieldW-1:0];
         out_rem_in = rem_sgn[FieldW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[WIDTH-1];
      end
   end

   always_ff @(posedge clock) begin
      out_quo_ff <= out_quo_in;
      out_rem_ff <= out_rem_in;
      out_dbz_ff <= out_dbz_in;
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_quotient       = out_quo_ff;
   assign rsp_remainder      = out_rem_ff;
   assign rsp_divide_by_zero = out_dbz_ff;

endmodule

`default_nettype wire

// ===== sv/signed_restoring_divider_unit.sv =====
// A taken beat goes through the queue, the WIDTH restoring stages and the sign
//   fix-up register; its result is then strobed on rsp_valid.
// Throughput: one beat per cycle, set by the WIDTH-stage restoring pipe.
// Reset: synchronous, active high; clears the queue and all valid bits.
// The receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none

module signed_restoring_divider_unit #(
   parameter int WIDTH = srd_pkg::DefaultWidth
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [srd_pkg::FieldW-1:0] req_dividend,
   input  wire logic [srd_pkg::FieldW-1:0] req_divisor,
   output logic                            rsp_valid,
   output logic [srd_pkg::FieldW-1:0]      rsp_quotient,
   output logic [srd_pkg::FieldW-1:0]      rsp_remainder,
   output logic                            rsp_divide_by_zero
);
   import srd_pkg::*;

   // Front: classify the beat (signs, clamped magnitudes, zero divisor)
   logic             push;
   logic [WIDTH-1:0] push_num;
   logic [WIDTH-1:0] push_den;
   tag_type          push_tag;

   // Queue between front and pipe
   logic             queue_full;
   logic             head_valid;
   logic [WIDTH-1:0] head_num;
   logic [WIDTH-1:0] head_den;
   tag_type          head_tag;

   // Hold off new beats only while the queue is full
   assign busy = queue_full;

   srd_front #(
      .WIDTH (WIDTH)
   ) u_front (
      .start        (start),
      .queue_full   (queue_full),
      .req_dividend (req_dividend),
      .req_divisor  (req_divisor),
      .push         (push),
      .push_num     (push_num),
      .push_den     (push_den),
      .push_tag     (push_tag)
   );

   srd_queue #(
      .WIDTH (WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_num   (push_num),
      .push_den   (push_den),
      .push_tag   (push_tag),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_num   (head_num),
      .head_den   (head_den),
      .head_tag   (head_tag)
   );

   // Back: one shift-subtract round per stage, then sign fix-up register
   srd_back #(
      .WIDTH (WIDTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (head_valid),
      .in_num             (head_num),
      .in_den             (head_den),
      .in_tag             (head_tag),
      .rsp_valid          (rsp_valid),
      .rsp_quotient       (rsp_quotient),
      .rsp_remainder      (rsp_remainder),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule

`default_nettype wire

// ===== sv/srd_checker.sv =====
`default_nettype none

module srd_checker #(
   parameter int WIDTH = srd_pkg::DefaultWidth
) (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       start,
   input wire logic                       busy,
   input wire logic [srd_pkg::FieldW-1:0] req_dividend,
   input wire logic [srd_pkg::FieldW-1:0] req_divisor,
   input wire logic                       rsp_valid,
   input wire logic [srd_pkg::FieldW-1:0] rsp_quotient,
   input wire logic [srd_pkg::FieldW-1:0] rsp_remainder,
   input wire logic                       rsp_divide_by_zero
);

   localparam int Lat = WIDTH + 2;

   // no strobe right after a reset cycle
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // the pipe drains every cycle, so the queue never fills
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // every accepted beat comes back after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##Lat rsp_valid)
      else $error("result missing at expected latency");

   // zero divisor gives a flagged result with the dividend passed through
   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_divisor == '0) |-> ##Lat
         (rsp_divide_by_zero && rsp_quotient == '0 &&
          rsp_remainder == $past(req_dividend, Lat)))
      else $error("zero divisor result wrong");

endmodule

bind signed_restoring_divider_unit srd_checker #(
   .WIDTH (WIDTH)
) u_srd_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_dividend       (req_dividend),
   .req_divisor        (req_divisor),
   .rsp_valid          (rsp_valid),
   .rsp_quotient       (rsp_quotient),
   .rsp_remainder      (rsp_remainder),
   .rsp_divide_by_zero (rsp_divide_by_zero)
);

`default_nettype wire
